FILE: hw/rtl/ptme_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page table map/unmap engine package
// Shared types, codes and descriptor constants for the engine's modules.
// ---------------------------------------------------------------------------
package ptme_pkg;

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 64;
	localparam int IN_DW  = 136;
	localparam int OUT_DW = 72;

	// Register indexes taken from paddr[4:3]
	localparam logic [1:0] REG_VA_BITS   = 2'd0;
	localparam logic [1:0] REG_POOL_BASE = 2'd1;
	localparam logic [1:0] REG_READY     = 2'd2;

	localparam logic [5:0] VA_BITS_MIN = 6'd30;
	localparam logic [5:0] VA_BITS_MAX = 6'd39;

	localparam logic [63:0] ATTR_AF       = 64'h0000_0000_0000_0400;
	localparam logic [63:0] ATTR_SH_INNER = 64'h0000_0000_0000_0300;
	localparam logic [63:0] ATTR_AP_RO    = 64'h0000_0000_0000_0080;
	localparam logic [63:0] ATTR_PXN      = 64'h0020_0000_0000_0000;
	localparam logic [63:0] ATTR_UXN      = 64'h0040_0000_0000_0000;
	localparam logic [63:0] ATTR_IDX_WB   = 64'h0000_0000_0000_0004;
	localparam logic [63:0] ATTR_IDX_NC   = 64'h0000_0000_0000_0008;

	typedef enum logic [1:0] {
		KIND_MAP    = 2'd0,
		KIND_UNMAP  = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_NOT_READY      = 3'd1,
		ST_NO_ACCESS      = 3'd2,
		ST_BEYOND_VA      = 3'd3,
		ST_VA_WIDTH       = 3'd4,
		ST_POOL_EXHAUSTED = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		LEAF_ZERO  = 2'd0,
		LEAF_BLOCK = 2'd1,
		LEAF_PAGE  = 2'd2
	} leaf_t;

	typedef enum logic [1:0] {
		STEP_2M     = 2'd0,
		STEP_4K     = 2'd1,
		STEP_SKIP1G = 2'd2,
		STEP_SKIP2M = 2'd3
	} step_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_CHECK,
		S_L1RD, S_L1EN, S_L1DEC,
		S_L2RD, S_L2EN, S_L2DEC,
		S_L3RD, S_L3EN, S_L3DEC,
		S_FILL, S_PTR, S_L3WR, S_NEXT, S_FIN
	} state_t;

	typedef struct packed {
		logic [5:0]  va_bits;
		logic [47:0] pool_base;
		logic        ready;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       take_pre;
		logic       st_we;
		status_t    st_code;
		logic       rd_l1;
		logic       rd_pool;
		logic       idx_l3;
		logic       ent_ld;
		logic       tbl_ld;
		logic       alloc;
		logic       fill;
		logic       child_l3;
		logic       wr_ptr;
		logic       wr_loc;
		logic       wr_l3;
		leaf_t      leaf_sel;
		logic       adv;
		step_t      step;
		logic       leaf_ld;
		logic [1:0] leaf_lvl;
		logic       clr_l1;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		status_t pre_status;
		kind_t   kind;
		logic    ent_valid;
		logic    ent_table;
		logic    tbl_ok;
		logic    pool_full;
		logic    map_blk;
		logic    unmap_blk;
		logic    range_done;
		logic    fill_last;
		logic    out_busy;
	} sts_t;

endpackage

FILE: hw/rtl/ptme_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page table engine configuration registers
// APB-style register file holding VA width, pool base and the ready flag.
// ---------------------------------------------------------------------------
module ptme_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ptme_pkg::CFG_AW-1:0]  paddr,
	input  logic [ptme_pkg::CFG_DW-1:0]  pwdata,
	output logic [ptme_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready,
	output ptme_pkg::cfg_t               cfg
);

	logic [5:0]  va_bits_q;
	logic [47:0] pool_base_q;
	logic        ready_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_bits_q   <= 6'd35;
			pool_base_q <= '0;
			ready_q     <= 1'b1;
		end else if (wr_en) begin
			unique case (paddr[4:3])
				ptme_pkg::REG_VA_BITS:   va_bits_q   <= pwdata[5:0];
				ptme_pkg::REG_POOL_BASE: pool_base_q <= pwdata[47:0];
				ptme_pkg::REG_READY:     ready_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			ptme_pkg::REG_VA_BITS:   prdata = {58'b0, va_bits_q};
			ptme_pkg::REG_POOL_BASE: prdata = {16'b0, pool_base_q};
			ptme_pkg::REG_READY:     prdata = {63'b0, ready_q};
			default:                 prdata = '0;
		endcase
	end

	assign cfg.va_bits   = va_bits_q;
	assign cfg.pool_base = pool_base_q;
	assign cfg.ready     = ready_q;

endmodule

FILE: hw/rtl/ptme_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page table engine datapath
// Request registers, walk address arithmetic, table memories and result.
// ---------------------------------------------------------------------------
module ptme_dp #(
	parameter int POOL_PAGES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ptme_pkg::cfg_t               cfg,
	input  ptme_pkg::cmd_t               cmd,
	output ptme_pkg::sts_t               sts,
	input  logic [ptme_pkg::IN_DW-1:0]   s_tdata,
	input  logic [1:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ptme_pkg::OUT_DW-1:0]  m_tdata
);

	localparam int PW    = $clog2(POOL_PAGES);
	localparam int AW    = PW + 9;
	localparam int DEPTH = POOL_PAGES * 512;

	ptme_pkg::kind_t   kind_q;
	ptme_pkg::status_t status_q;
	logic [47:0] va_q, pa_q;
	logic [33:0] size_q, off_q;
	logic        len_zero_q, acc_none_q;
	logic [63:0] attr_q, ent_q, desc_q;
	logic [1:0]  lvl_q;
	logic [PW-1:0] tbl_q, loc_pg_q;
	logic [8:0]  loc_idx_q, fill_i_q;
	logic        loc_l1_q;
	logic [PW:0] nfp_q;
	logic        m_valid_q;
	logic [ptme_pkg::OUT_DW-1:0] m_data_q;
	logic [63:0] l1_rd_q, pool_rd_q;

	logic [63:0] l1_mem [512];
	logic [63:0] pool_mem [DEPTH];

	// Request fields
	logic [47:0] in_va, in_pa;
	logic [31:0] in_len;
	logic        in_rd, in_wr, in_ex, in_dev, in_wt;
	logic [11:0] in_low;
	logic [33:0] in_size;
	logic [63:0] in_attr;

	// Walk arithmetic
	logic [47:0] cur_v, cur_p, fill_oa, step48;
	logic [3:0]  l1_sh;
	logic [8:0]  l1_mask, l1_idx, idx2, idx3;
	logic [33:0] rem, step34;
	logic [35:0] tbl_idx;
	logic [63:0] ent, fill_desc, ptr_desc, leaf_desc;
	logic        vb_ok, beyond_rng, beyond_pt;
	logic [49:0] lim50, sum50;
	ptme_pkg::status_t pre;

	logic          pool_we, l1_we;
	logic [AW-1:0] pool_wa, pool_ra;
	logic [63:0]   pool_wd, l1_wd;
	logic [8:0]    l1_wa;

	assign in_va   = s_tdata[47:0];
	assign in_pa   = s_tdata[95:48];
	assign in_len  = s_tdata[127:96];
	assign in_rd   = s_tdata[128];
	assign in_wr   = s_tdata[129];
	assign in_ex   = s_tdata[130];
	assign in_dev  = s_tdata[131] | s_tdata[132];
	assign in_wt   = s_tdata[133];
	assign in_low  = (ptme_pkg::kind_t'(s_tuser) == ptme_pkg::KIND_MAP) ? in_pa[11:0] : in_va[11:0];
	assign in_size = (34'(in_len) + 34'(in_low) + 34'h0fff) & ~34'h0fff;

	always_comb begin
		in_attr = ptme_pkg::ATTR_AF;
		if (in_dev)
			in_attr = in_attr | ptme_pkg::ATTR_PXN | ptme_pkg::ATTR_UXN;
		else if (in_wt)
			in_attr = in_attr | ptme_pkg::ATTR_IDX_NC | ptme_pkg::ATTR_SH_INNER;
		else
			in_attr = in_attr | ptme_pkg::ATTR_IDX_WB | ptme_pkg::ATTR_SH_INNER;
		if (!in_wr)
			in_attr = in_attr | ptme_pkg::ATTR_AP_RO;
	end

	assign cur_v   = {va_q[47:12], 12'b0} + 48'(off_q);
	assign cur_p   = {pa_q[47:12] + 36'(off_q[33:12]), 12'b0};
	assign l1_sh   = 4'(cfg.va_bits - ptme_pkg::VA_BITS_MIN);
	assign l1_mask = ~(9'h1ff << l1_sh);
	assign l1_idx  = cur_v[38:30] & l1_mask;
	assign idx2    = cur_v[29:21];
	assign idx3    = cur_v[20:12];
	assign rem     = size_q - off_q;
	assign ent     = loc_l1_q ? l1_rd_q : pool_rd_q;

	// Page index of a table pointer, relative to the pool base, wrapping in 36 bits.
	assign tbl_idx = ent_q[47:12] - cfg.pool_base[47:12];

	// Range checks
	assign vb_ok      = (cfg.va_bits >= ptme_pkg::VA_BITS_MIN) &&
	                    (cfg.va_bits <= ptme_pkg::VA_BITS_MAX);
	assign lim50      = 50'(1) << cfg.va_bits;
	assign sum50      = 50'({va_q[47:12], 12'b0}) + 50'(size_q);
	assign beyond_rng = (cfg.va_bits < 6'd50) && (sum50 > lim50);
	assign beyond_pt  = (cfg.va_bits < 6'd50) && (50'(va_q) >= lim50);

	always_comb begin
		pre = ptme_pkg::ST_OK;
		case (kind_q)
			ptme_pkg::KIND_MAP: begin
				if (!cfg.ready || len_zero_q)  pre = ptme_pkg::ST_NOT_READY;
				else if (acc_none_q)           pre = ptme_pkg::ST_NO_ACCESS;
				else if (beyond_rng)           pre = ptme_pkg::ST_BEYOND_VA;
				else if (!vb_ok)               pre = ptme_pkg::ST_VA_WIDTH;
			end
			ptme_pkg::KIND_UNMAP: begin
				if (!cfg.ready || len_zero_q)  pre = ptme_pkg::ST_NOT_READY;
				else if (beyond_rng)           pre = ptme_pkg::ST_BEYOND_VA;
				else if (!vb_ok)               pre = ptme_pkg::ST_VA_WIDTH;
			end
			ptme_pkg::KIND_LOOKUP: begin
				if (!vb_ok)                    pre = ptme_pkg::ST_VA_WIDTH;
				else if (beyond_pt)            pre = ptme_pkg::ST_BEYOND_VA;
			end
			default: pre = ptme_pkg::ST_OK;
		endcase
	end

	// Descriptor values
	assign step48    = cmd.child_l3 ? {27'b0, fill_i_q, 12'b0} : {18'b0, fill_i_q, 21'b0};
	assign fill_oa   = {ent_q[47:12], 12'b0} + step48;
	assign fill_desc = ent_q[0] ? {ent_q[63:48], fill_oa[47:12], ent_q[11:2],
	                               cmd.child_l3, 1'b1} : 64'b0;
	assign ptr_desc  = {16'b0, cfg.pool_base[47:12] + 36'(tbl_q), 10'b0, 2'b11};

	always_comb begin
		case (cmd.leaf_sel)
			ptme_pkg::LEAF_BLOCK: leaf_desc = {16'b0, cur_p[47:12], 12'b0} | attr_q | 64'h1;
			ptme_pkg::LEAF_PAGE:  leaf_desc = {16'b0, cur_p[47:12], 12'b0} | attr_q | 64'h3;
			default:              leaf_desc = '0;
		endcase
	end

	always_comb begin
		case (cmd.step)
			ptme_pkg::STEP_2M:     step34 = 34'h0020_0000;
			ptme_pkg::STEP_4K:     step34 = 34'h0000_1000;
			ptme_pkg::STEP_SKIP1G: step34 = 34'h4000_0000 - 34'(cur_v[29:0]);
			default:               step34 = 34'h0020_0000 - 34'(cur_v[20:0]);
		endcase
	end

	// Memory port selection
	always_comb begin
		pool_we = 1'b0;
		pool_wa = {loc_pg_q, loc_idx_q};
		pool_wd = leaf_desc;
		if (cmd.fill) begin
			pool_we = 1'b1;
			pool_wa = {tbl_q, fill_i_q};
			pool_wd = fill_desc;
		end else if (cmd.wr_ptr && !loc_l1_q) begin
			pool_we = 1'b1;
			pool_wd = ptr_desc;
		end else if (cmd.wr_loc) begin
			pool_we = 1'b1;
		end else if (cmd.wr_l3) begin
			pool_we = 1'b1;
			pool_wa = {tbl_q, idx3};
		end
	end

	assign pool_ra = {tbl_q, cmd.idx_l3 ? idx3 : idx2};
	assign l1_we   = cmd.clr_l1 | (cmd.wr_ptr & loc_l1_q);
	assign l1_wa   = cmd.clr_l1 ? fill_i_q : loc_idx_q;
	assign l1_wd   = cmd.clr_l1 ? 64'b0 : ptr_desc;

	always_ff @(posedge clk) begin
		if (pool_we)
			pool_mem[pool_wa] <= pool_wd;
		if (cmd.rd_pool)
			pool_rd_q <= pool_mem[pool_ra];
	end

	always_ff @(posedge clk) begin
		if (l1_we)
			l1_mem[l1_wa] <= l1_wd;
		if (cmd.rd_l1)
			l1_rd_q <= l1_mem[l1_idx];
	end

	// Request and walk payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q     <= ptme_pkg::kind_t'(s_tuser);
			va_q       <= in_va;
			pa_q       <= {in_pa[47:12], 12'b0};
			size_q     <= in_size;
			len_zero_q <= (in_len == 32'b0);
			acc_none_q <= !(in_rd | in_wr | in_ex);
			attr_q     <= in_attr;
			off_q      <= '0;
			desc_q     <= '0;
			lvl_q      <= '0;
		end else begin
			if (cmd.adv)
				off_q <= off_q + step34;
			if (cmd.leaf_ld) begin
				desc_q <= ent_q;
				lvl_q  <= cmd.leaf_lvl;
			end
		end
		if (cmd.take_pre)
			status_q <= pre;
		else if (cmd.st_we)
			status_q <= cmd.st_code;
		if (cmd.ent_ld)
			ent_q <= ent;
		if (cmd.rd_l1) begin
			loc_l1_q  <= 1'b1;
			loc_idx_q <= l1_idx;
		end else if (cmd.rd_pool) begin
			loc_l1_q  <= 1'b0;
			loc_pg_q  <= tbl_q;
			loc_idx_q <= cmd.idx_l3 ? idx3 : idx2;
		end
		if (cmd.alloc)
			tbl_q <= nfp_q[PW-1:0];
		else if (cmd.tbl_ld)
			tbl_q <= tbl_idx[PW-1:0];
		if (cmd.out_load)
			m_data_q <= {3'b0, lvl_q, desc_q, status_q};
	end

	// Allocation pointer, sweep counter and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nfp_q     <= '0;
			fill_i_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.alloc) begin
				nfp_q    <= nfp_q + 1'b1;
				fill_i_q <= '0;
			end else if (cmd.fill || cmd.clr_l1) begin
				fill_i_q <= fill_i_q + 1'b1;
			end
			if (cmd.out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign sts.pre_status = pre;
	assign sts.kind       = kind_q;
	assign sts.ent_valid  = ent_q[0];
	assign sts.ent_table  = ent_q[1];
	assign sts.tbl_ok     = tbl_idx < 36'(nfp_q);
	assign sts.pool_full  = (nfp_q == (PW+1)'(POOL_PAGES));
	assign sts.map_blk    = (cur_v[20:0] == 21'b0) && (cur_p[20:12] == 9'b0) &&
	                        (rem >= 34'h0020_0000) && !(ent_q[0] && ent_q[1]);
	assign sts.unmap_blk  = (cur_v[20:0] == 21'b0) && (rem >= 34'h0020_0000) && !ent_q[1];
	assign sts.range_done = (off_q >= size_q);
	assign sts.fill_last  = (fill_i_q == 9'h1ff);
	assign sts.out_busy   = m_valid_q & ~m_tready;

endmodule

FILE: hw/rtl/ptme_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page table engine controller
// Sequences the table walk, allocation, block splitting and result transfer.
// ---------------------------------------------------------------------------
module ptme_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  ptme_pkg::sts_t sts,
	output ptme_pkg::cmd_t cmd
);

	ptme_pkg::state_t state_q, state_d;
	logic child_l3_q, child_l3_d;
	logic is_map, is_unmap, is_lookup;

	assign is_map    = (sts.kind == ptme_pkg::KIND_MAP);
	assign is_unmap  = (sts.kind == ptme_pkg::KIND_UNMAP);
	assign is_lookup = (sts.kind == ptme_pkg::KIND_LOOKUP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ptme_pkg::S_CLR;
			child_l3_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			child_l3_q <= child_l3_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		child_l3_d = child_l3_q;
		cmd        = '0;
		s_tready   = 1'b0;
		unique case (state_q)
			ptme_pkg::S_CLR: begin
				cmd.clr_l1 = 1'b1;
				if (sts.fill_last)
					state_d = ptme_pkg::S_IDLE;
			end
			ptme_pkg::S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid)
					state_d = ptme_pkg::S_CHECK;
			end
			ptme_pkg::S_CHECK: begin
				cmd.take_pre = 1'b1;
				if (sts.pre_status != ptme_pkg::ST_OK || sts.kind == ptme_pkg::KIND_NOP)
					state_d = ptme_pkg::S_FIN;
				else
					state_d = ptme_pkg::S_L1RD;
			end
			ptme_pkg::S_L1RD: begin
				cmd.rd_l1 = 1'b1;
				state_d   = ptme_pkg::S_L1EN;
			end
			ptme_pkg::S_L1EN: begin
				cmd.ent_ld = 1'b1;
				state_d    = ptme_pkg::S_L1DEC;
			end
			ptme_pkg::S_L1DEC: begin
				if (is_lookup) begin
					if (!sts.ent_valid) begin
						state_d = ptme_pkg::S_FIN;
					end else if (!sts.ent_table) begin
						cmd.leaf_ld  = 1'b1;
						cmd.leaf_lvl = 2'd1;
						state_d      = ptme_pkg::S_FIN;
					end else begin
						cmd.tbl_ld = 1'b1;
						state_d    = sts.tbl_ok ? ptme_pkg::S_L2RD : ptme_pkg::S_FIN;
					end
				end else if (is_unmap && !sts.ent_valid) begin
					cmd.adv  = 1'b1;
					cmd.step = ptme_pkg::STEP_SKIP1G;
					state_d  = ptme_pkg::S_NEXT;
				end else if (sts.ent_valid && sts.ent_table) begin
					if (sts.tbl_ok) begin
						cmd.tbl_ld = 1'b1;
						state_d    = ptme_pkg::S_L2RD;
					end else begin
						cmd.st_we   = 1'b1;
						cmd.st_code = ptme_pkg::ST_POOL_EXHAUSTED;
						state_d     = ptme_pkg::S_FIN;
					end
				end else if (sts.pool_full) begin
					cmd.st_we   = 1'b1;
					cmd.st_code = ptme_pkg::ST_POOL_EXHAUSTED;
					state_d     = ptme_pkg::S_FIN;
				end else begin
					cmd.alloc  = 1'b1;
					child_l3_d = 1'b0;
					state_d    = ptme_pkg::S_FILL;
				end
			end
			ptme_pkg::S_L2RD: begin
				cmd.rd_pool = 1'b1;
				state_d     = ptme_pkg::S_L2EN;
			end
			ptme_pkg::S_L2EN: begin
				cmd.ent_ld = 1'b1;
				state_d    = ptme_pkg::S_L2DEC;
			end
			ptme_pkg::S_L2DEC: begin
				if (is_lookup) begin
					if (!sts.ent_valid) begin
						state_d = ptme_pkg::S_FIN;
					end else if (!sts.ent_table) begin
						cmd.leaf_ld  = 1'b1;
						cmd.leaf_lvl = 2'd2;
						state_d      = ptme_pkg::S_FIN;
					end else begin
						cmd.tbl_ld = 1'b1;
						state_d    = sts.tbl_ok ? ptme_pkg::S_L3RD : ptme_pkg::S_FIN;
					end
				end else if (is_unmap && !sts.ent_valid) begin
					cmd.adv  = 1'b1;
					cmd.step = ptme_pkg::STEP_SKIP2M;
					state_d  = ptme_pkg::S_NEXT;
				end else if ((is_map && sts.map_blk) || (is_unmap && sts.unmap_blk)) begin
					cmd.wr_loc   = 1'b1;
					cmd.leaf_sel = is_map ? ptme_pkg::LEAF_BLOCK : ptme_pkg::LEAF_ZERO;
					cmd.adv      = 1'b1;
					cmd.step     = ptme_pkg::STEP_2M;
					state_d      = ptme_pkg::S_NEXT;
				end else if (sts.ent_valid && sts.ent_table) begin
					if (sts.tbl_ok) begin
						cmd.tbl_ld = 1'b1;
						state_d    = ptme_pkg::S_L3WR;
					end else begin
						cmd.st_we   = 1'b1;
						cmd.st_code = ptme_pkg::ST_POOL_EXHAUSTED;
						state_d     = ptme_pkg::S_FIN;
					end
				end else if (sts.pool_full) begin
					cmd.st_we   = 1'b1;
					cmd.st_code = ptme_pkg::ST_POOL_EXHAUSTED;
					state_d     = ptme_pkg::S_FIN;
				end else begin
					cmd.alloc  = 1'b1;
					child_l3_d = 1'b1;
					state_d    = ptme_pkg::S_FILL;
				end
			end
			ptme_pkg::S_L3RD: begin
				cmd.rd_pool = 1'b1;
				cmd.idx_l3  = 1'b1;
				state_d     = ptme_pkg::S_L3EN;
			end
			ptme_pkg::S_L3EN: begin
				cmd.ent_ld = 1'b1;
				state_d    = ptme_pkg::S_L3DEC;
			end
			ptme_pkg::S_L3DEC: begin
				cmd.leaf_ld  = sts.ent_valid;
				cmd.leaf_lvl = 2'd3;
				state_d      = ptme_pkg::S_FIN;
			end
			ptme_pkg::S_FILL: begin
				// A fresh table page is either cleared or filled with the split block.
				cmd.fill     = 1'b1;
				cmd.child_l3 = child_l3_q;
				if (sts.fill_last)
					state_d = ptme_pkg::S_PTR;
			end
			ptme_pkg::S_PTR: begin
				cmd.wr_ptr = 1'b1;
				state_d    = child_l3_q ? ptme_pkg::S_L3WR : ptme_pkg::S_L2RD;
			end
			ptme_pkg::S_L3WR: begin
				cmd.wr_l3    = 1'b1;
				cmd.leaf_sel = is_map ? ptme_pkg::LEAF_PAGE : ptme_pkg::LEAF_ZERO;
				cmd.adv      = 1'b1;
				cmd.step     = ptme_pkg::STEP_4K;
				state_d      = ptme_pkg::S_NEXT;
			end
			ptme_pkg::S_NEXT: begin
				state_d = sts.range_done ? ptme_pkg::S_FIN : ptme_pkg::S_L1RD;
			end
			ptme_pkg::S_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ptme_pkg::S_IDLE;
				end
			end
			default: state_d = ptme_pkg::S_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/page_table_map_unmap_engine_top.sv
`timescale 1ns / 1ps
// Map and unmap write 2MB blocks and 4KB pages, and each table page allocated
// is cleared or filled one entry a cycle.
// One request at a time; the next is taken once the result sits in the output register.
// After reset a clearing pass zeroes the first-level table before input is taken.
// ---------------------------------------------------------------------------
// Page table map/unmap engine
// AArch64 stage-1 4KB-granule table builder with lookup, in internal memory.
// ---------------------------------------------------------------------------
module page_table_map_unmap_engine_top #(
	parameter int POOL_PAGES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// virt_addr[47:0], phys_addr[95:48], length[127:96], can_read[128], can_write[129],
	// can_execute[130], cache_inhibit[131], guarded[132], write_through[133], zero pad
	input  logic [ptme_pkg::IN_DW-1:0]   s_tdata,
	// kind[1:0]
	input  logic [1:0]                   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status[2:0], descriptor[66:3], level[68:67], zero pad
	output logic [ptme_pkg::OUT_DW-1:0]  m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ptme_pkg::CFG_AW-1:0]  paddr,
	input  logic [ptme_pkg::CFG_DW-1:0]  pwdata,
	output logic [ptme_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready
);

	ptme_pkg::cfg_t cfg;
	ptme_pkg::cmd_t cmd;
	ptme_pkg::sts_t sts;

	ptme_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ptme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptme_dp #(
		.POOL_PAGES (POOL_PAGES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
